// ===== rtl/ict_pkg.sv =====
// Shared types, constants and request codes for the clock tracker.
`default_nettype none
package ict_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned MUL_W      = 30;   // small operand of the shared unit

    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_STOP  = 3'd1;
    localparam logic [2:0] REQ_TS    = 3'd2;
    localparam logic [2:0] REQ_P2T   = 3'd3;
    localparam logic [2:0] REQ_T2P   = 3'd4;

    localparam logic [1:0] TRK_STOPPED  = 2'd0;
    localparam logic [1:0] TRK_STARTING = 2'd1;
    localparam logic [1:0] TRK_SYNCING  = 2'd2;
    localparam logic [1:0] TRK_RUNNING  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_FRAMES = 2'd1;

    localparam logic [17:0]      RATE_RESET  = 18'd48000;
    localparam logic [12:0]      BURST_RESET = 13'd64;
    localparam logic [MUL_W-1:0] NS_PER_SEC  = 30'd1000000000;
    localparam logic [63:0]      MIN_GAP_NS  = 64'd1000;
    localparam logic [63:0]      MIN_LATE_NS = 64'd10000;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [62:0] frame_position;
        logic [62:0] nano_time;
    } ict_in_t;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         clock_state;
    } ict_out_t;

    // command to the shared multiply / divide unit
    typedef struct packed {
        logic             start;
        logic             is_mul;
        logic [63:0]      a;
        logic [MUL_W-1:0] m;
    } ict_alu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } ict_alu_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/ict_alu.sv =====
// Shared shift-add multiplier and restoring signed divider, one bit per cycle.
`default_nettype none
module ict_alu
    import ict_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire ict_alu_req_t req,
    output ict_alu_rsp_t      rsp
);

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_DIV  = 4'b0100,
        U_FIX  = 4'b1000
    } ustate_t;

    ustate_t          state_reg, state_next;
    logic [63:0]      sh_reg, sh_next;
    logic [63:0]      work_reg, work_next;
    logic [MUL_W-1:0] m_reg, m_next;
    logic [MUL_W-1:0] rem_reg, rem_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             mul_reg, mul_next;
    logic [63:0]      res_reg, res_next;
    logic             done_reg, done_next;

    logic [MUL_W:0] trial;
    logic           ge;
    logic [63:0]    sel;

    always_comb begin
        trial = {rem_reg, sh_reg[63]};
        ge    = trial >= {1'b0, m_reg};
        sel   = mul_reg ? work_reg : sh_reg;

        state_next = state_reg;
        sh_next    = sh_reg;
        work_next  = work_reg;
        m_next     = m_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        mul_next   = mul_reg;
        res_next   = res_reg;
        done_next  = 1'b0;

        case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    m_next   = req.m;
                    mul_next = req.is_mul;
                    rem_next = '0;
                    work_next = '0;
                    if (req.is_mul) begin
                        sh_next    = req.a;
                        neg_next   = 1'b0;
                        cnt_next   = 6'(MUL_W - 1);
                        state_next = U_MUL;
                    end else begin
                        neg_next   = req.a[63];
                        sh_next    = req.a[63] ? (64'd0 - req.a) : req.a;
                        cnt_next   = 6'd63;
                        state_next = U_DIV;
                    end
                end
            end
            U_MUL: begin
                if (m_reg[0]) begin
                    work_next = work_reg + sh_reg;
                end
                sh_next  = {sh_reg[62:0], 1'b0};
                m_next   = {1'b0, m_reg[MUL_W-1:1]};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    state_next = U_FIX;
                end
            end
            U_DIV: begin
                rem_next = ge ? MUL_W'(trial - {1'b0, m_reg}) : trial[MUL_W-1:0];
                sh_next  = {sh_reg[62:0], ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    state_next = U_FIX;
                end
            end
            U_FIX: begin
                res_next   = neg_reg ? (64'd0 - sel) : sel;
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        sh_reg   <= sh_next;
        work_reg <= work_next;
        m_reg    <= m_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        mul_reg  <= mul_next;
        res_reg  <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule
`default_nettype wire

// ===== rtl/isochronous_clock_tracker_core.sv =====
// Top level: frame clock tracker, a sequencer over one shared multiply/divide unit.
// Work per request: start, unknown codes, any request while stopped and timestamps inside the
// minimum gap skip the shared unit; stop and other timestamps outside running use a multiply
// and a divide; timestamps while running and both conversions use two of each.
// One word in flight; s_ready returns the cycle after the result handshake.
// Reset: synchronous active-low aresetn; tracker stopped, marker zero, registers default.
`default_nettype none
module isochronous_clock_tracker_core
    import ict_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire ict_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ict_out_t                   m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_WAIT  = 5'b00100,
        S_FIN   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  step_reg, step_next;
    logic [2:0]  req_reg, req_next;
    logic [63:0] pos_reg, pos_next;
    logic [63:0] t_reg, t_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] e_reg, e_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mp_reg, mp_next;
    logic [63:0] mt_reg, mt_next;
    logic [1:0]  trk_reg, trk_next;
    logic [17:0] rate_reg, rate_next;
    logic [12:0] burst_reg, burst_next;
    ict_out_t    out_reg, out_next;

    ict_alu_req_t alu_req;
    ict_alu_rsp_t alu_rsp;

    logic [MUL_W-1:0] rate_div, burst_div;
    logic [63:0]      in_pos, in_t, in_d, late;
    logic             in_work;
    logic [1:0]       last_step;

    ict_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    // zero divisors count as one
    assign rate_div  = (rate_reg == '0)  ? MUL_W'(1) : MUL_W'(rate_reg);
    assign burst_div = (burst_reg == '0) ? MUL_W'(1) : MUL_W'(burst_reg);

    assign in_pos = {1'b0, s_data.frame_position};
    assign in_t   = {1'b0, s_data.nano_time};
    assign in_d   = in_t - mt_reg;

    // does this word need the shared unit at all
    always_comb begin
        in_work = 1'b0;
        if (trk_reg != TRK_STOPPED) begin
            case (s_data.req_type)
                REQ_STOP, REQ_P2T, REQ_T2P: in_work = 1'b1;
                REQ_TS:  in_work = !($signed(in_d) < $signed(MIN_GAP_NS));
                default: in_work = 1'b0;
            endcase
        end
    end

    // stop ends after its multiply; timestamps outside running stop after the expected-time divide
    assign last_step = ((req_reg == REQ_STOP) ||
                        (req_reg == REQ_TS && trk_reg != TRK_RUNNING)) ? 2'd1 : 2'd3;

    // operand selection per request and step
    always_comb begin
        alu_req.start  = (state_reg == S_ISSUE);
        alu_req.is_mul = 1'b0;
        alu_req.a      = acc_reg;
        alu_req.m      = rate_div;
        case (req_reg)
            REQ_STOP: begin
                alu_req.is_mul = (step_reg == 2'd1);
                alu_req.a      = (step_reg == 2'd0) ? mp_reg : acc_reg;
                alu_req.m      = burst_div;
            end
            REQ_TS: begin
                case (step_reg)
                    2'd0: begin
                        alu_req.is_mul = 1'b1;
                        alu_req.a      = pos_reg - mp_reg;
                        alu_req.m      = NS_PER_SEC;
                    end
                    2'd2: begin
                        alu_req.is_mul = 1'b1;
                        alu_req.a      = 64'(burst_reg);
                        alu_req.m      = NS_PER_SEC;
                    end
                    default: begin
                        alu_req.m = rate_div;
                    end
                endcase
            end
            REQ_P2T: begin
                case (step_reg)
                    2'd0: begin
                        // round up to the next burst boundary
                        alu_req.a = pos_reg + 64'(burst_div) - 64'd1;
                        alu_req.m = burst_div;
                    end
                    2'd1: begin
                        alu_req.is_mul = 1'b1;
                        alu_req.m      = burst_div;
                    end
                    2'd2: begin
                        alu_req.is_mul = 1'b1;
                        alu_req.a      = acc_reg - mp_reg;
                        alu_req.m      = NS_PER_SEC;
                    end
                    default: begin
                        alu_req.m = rate_div;
                    end
                endcase
            end
            REQ_T2P: begin
                case (step_reg)
                    2'd0: begin
                        alu_req.is_mul = 1'b1;
                        alu_req.a      = t_reg - mt_reg;
                        alu_req.m      = rate_div;
                    end
                    2'd1: begin
                        alu_req.m = NS_PER_SEC;
                    end
                    2'd2: begin
                        alu_req.a = mp_reg + acc_reg;
                        alu_req.m = burst_div;
                    end
                    default: begin
                        alu_req.is_mul = 1'b1;
                        alu_req.m      = burst_div;
                    end
                endcase
            end
            default: begin
                alu_req.a = acc_reg;
            end
        endcase
    end

    // lateness bound: burst duration, no less than the floor
    assign late = ($signed(MIN_LATE_NS) < $signed(acc_reg)) ? acc_reg : MIN_LATE_NS;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        req_next   = req_reg;
        pos_next   = pos_reg;
        t_next     = t_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        acc_next   = acc_reg;
        mp_next    = mp_reg;
        mt_next    = mt_reg;
        trk_next   = trk_reg;
        rate_next  = rate_reg;
        burst_next = burst_reg;
        out_next   = out_reg;

        // config writes land only while idle by contract: the user must keep to it, the block does not enforce it
        if (cfg_valid) begin
            if (cfg_index == CFG_SAMPLE_RATE) begin
                rate_next = cfg_data[17:0];
            end else if (cfg_index == CFG_BURST_FRAMES) begin
                burst_next = cfg_data[12:0];
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data.req_type;
                    pos_next   = in_pos;
                    t_next     = in_t;
                    d_next     = in_d;
                    step_next  = 2'd0;
                    state_next = in_work ? S_ISSUE : S_FIN;
                end
            end
            S_ISSUE: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    acc_next = alu_rsp.res;
                    if (req_reg == REQ_TS && step_reg == 2'd1) begin
                        e_next = alu_rsp.res;
                    end
                    if (step_reg == last_step) begin
                        state_next = S_FIN;
                    end else begin
                        step_next  = step_reg + 2'd1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FIN: begin
                out_next.result_value = '0;
                case (req_reg)
                    REQ_START: begin
                        mt_next  = t_reg;
                        trk_next = TRK_STARTING;
                    end
                    REQ_STOP: begin
                        mt_next = t_reg;
                        if (trk_reg != TRK_STOPPED) begin
                            mp_next = acc_reg;
                        end
                        trk_next = TRK_STOPPED;
                    end
                    REQ_TS: begin
                        if (!($signed(d_reg) < $signed(MIN_GAP_NS))) begin
                            case (trk_reg)
                                TRK_STARTING: begin
                                    mp_next  = pos_reg;
                                    mt_next  = t_reg;
                                    trk_next = TRK_SYNCING;
                                end
                                TRK_SYNCING: begin
                                    if ($signed(d_reg) < $signed(e_reg)) begin
                                        mp_next = pos_reg;
                                        mt_next = t_reg;
                                    end else begin
                                        trk_next = TRK_RUNNING;
                                    end
                                end
                                TRK_RUNNING: begin
                                    if ($signed(d_reg) < $signed(e_reg)) begin
                                        mp_next = pos_reg;
                                        mt_next = t_reg;
                                    end else if ($signed(e_reg + late) < $signed(d_reg)) begin
                                        // too late: pull the marker back by the bound
                                        mp_next = pos_reg;
                                        mt_next = t_reg - late;
                                    end
                                end
                                default: begin
                                    trk_next = trk_reg;
                                end
                            endcase
                        end
                    end
                    REQ_P2T: begin
                        out_next.result_value = (trk_reg == TRK_STOPPED) ?
                                                mt_reg : (mt_reg + acc_reg);
                    end
                    REQ_T2P: begin
                        out_next.result_value = (trk_reg == TRK_STOPPED) ? mp_reg : acc_reg;
                    end
                    default: begin
                        out_next.result_value = '0;
                    end
                endcase
                out_next.clock_state = trk_next;
                state_next           = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= 2'd0;
            mp_reg    <= '0;
            mt_reg    <= '0;
            trk_reg   <= TRK_STOPPED;
            rate_reg  <= RATE_RESET;
            burst_reg <= BURST_RESET;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mp_reg    <= mp_next;
            mt_reg    <= mt_next;
            trk_reg   <= trk_next;
            rate_reg  <= rate_next;
            burst_reg <= burst_next;
        end
        req_reg <= req_next;
        pos_reg <= pos_next;
        t_reg   <= t_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ===== rtl/ict_checker.sv =====
// Port-level checks for the clock tracker, bound to the top level.
`default_nettype none
module ict_checker
    import ict_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire ict_out_t m_data
);

    // one word at a time: accept closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in flight");

    a_out_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input open while result pending");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped or changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind isochronous_clock_tracker_core ict_checker u_ict_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
